>>> design/gph_pkg.sv
// Shared types and constants for the grid point histogram.
package gph_pkg;

	localparam int COORD_W    = 32;
	localparam int STEP_W     = 31;
	localparam int CELLS_W    = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_STEPS  = 8;
	localparam int QUO_W      = DIV_STEPS;
	localparam int DVS_W      = STEP_W + QUO_W - 1;
	localparam int OUT_CNT_W  = 16;
	localparam int OUT_EMPTY_W = 13;

	localparam logic [STEP_W-1:0]  STEP_RST   = 31'd65536;
	localparam logic [CELLS_W-1:0] CELLS_RST  = 7'd64;
	localparam logic [31:0]        OUT_CNT_MAX = 32'h0000_FFFF;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_U_ORIGIN = 3'd0,
		REG_V_ORIGIN = 3'd1,
		REG_U_STEP   = 3'd2,
		REG_V_STEP   = 3'd3,
		REG_U_CELLS  = 3'd4,
		REG_V_CELLS  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DIV,
		ST_LOOK,
		ST_FIN,
		ST_CLR,
		ST_RCNT,
		ST_RCEND
	} gph_state_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] u_coord;
		logic signed [31:0] v_coord;
		logic [5:0]         read_col;
		logic [5:0]         read_row;
	} gph_in_t;

	typedef struct packed {
		logic [5:0]  cell_col;
		logic [5:0]  cell_row;
		logic        in_grid;
		logic [15:0] cell_count;
		logic [12:0] empty_cells;
	} gph_out_t;

	typedef struct packed {
		logic in_load;
		logic cfg_we;
		logic div_step;
		logic look;
		logic fin;
		logic swp_init;
		logic swp_adv;
		logic swp_full;
		logic clr_wr;
		logic rc_rd;
		logic rc_commit;
		logic empty_fill;
	} gph_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       swp_last;
	} gph_sts_t;

endpackage

>>> design/gph_div.sv
// Bit-serial axis index divider with saturation flag in the top quotient bit.
module gph_div import gph_pkg::*; (
	input  logic                      clk,
	input  logic                      load,
	input  logic                      advance,
	input  logic signed [COORD_W-1:0] coord,
	input  logic signed [COORD_W-1:0] origin,
	input  logic [STEP_W-1:0]         pitch,
	output logic [QUO_W-1:0]          quo
);

	logic [COORD_W:0]   diff_m1;
	logic [STEP_W-1:0]  pitch_eff;
	logic [COORD_W-1:0] rem_q;
	logic [DVS_W-1:0]   dvs_q;
	logic [QUO_W-1:0]   quo_q;
	logic               ge;

	assign diff_m1   = {coord[COORD_W-1], coord} + ~{origin[COORD_W-1], origin};
	assign pitch_eff = (pitch == '0) ? STEP_W'(1) : pitch;
	assign ge        = {{(DVS_W-COORD_W){1'b0}}, rem_q} >= dvs_q;
	assign quo       = quo_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= diff_m1[COORD_W] ? '0 : diff_m1[COORD_W-1:0];
			dvs_q <= {pitch_eff, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (advance) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q[COORD_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dvs_q <= dvs_q >> 1;
		end
	end

endmodule

>>> design/gph_datapath.sv
// Datapath: configuration registers, dividers, count store, sweep counters, result register.
module gph_datapath import gph_pkg::*; #(
	parameter int MAX_COLS   = 64,
	parameter int MAX_ROWS   = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gph_in_t               in_data,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  gph_cmd_t              cmd,
	output gph_sts_t              sts,
	output gph_out_t              out_data
);

	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MCC   = (MAX_COLS < 127) ? MAX_COLS : 127;
	localparam int MRC   = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int EW    = $clog2(MCC * MRC + 1);
	localparam int EMPTY_RST = ((MAX_COLS < 64) ? MAX_COLS : 64) *
		((MAX_ROWS < 64) ? MAX_ROWS : 64);
	localparam logic [AW-1:0] COLS_A   = AW'(MAX_COLS);
	localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

	function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [31:0] v);
		sat_count = (v > OUT_CNT_MAX) ? OUT_CNT_MAX[OUT_CNT_W-1:0] : v[OUT_CNT_W-1:0];
	endfunction

	logic signed [COORD_W-1:0] u_origin_q, v_origin_q;
	logic [STEP_W-1:0]         u_step_q, v_step_q;
	logic [CELLS_W-1:0]        u_cells_q, v_cells_q;
	logic [CELLS_W-1:0]        nc, nr;
	logic [EW-1:0]             area;

	logic [QUO_W-1:0] q_u, q_r;
	logic [1:0]       req_q;
	logic [5:0]       rcol_q, rrow_q;

	logic          pt_hit, rd_hit, look_hit;
	logic [AW-1:0] pt_addr, rd_addr_pt, look_addr, swp_addr;
	logic [CW-1:0] swp_col_q, lim_c;
	logic [RW-1:0] swp_row_q, lim_r;

	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rd_q, cnt_new, mem_wd;
	logic [AW-1:0]         mem_wa, mem_ra;
	logic                  mem_we, rd_en;

	logic [EW-1:0] empty_q, empty_nxt, acc_q, acc_nxt;
	logic          rc_v_s1;
	gph_out_t      res, out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_origin_q <= '0;
			v_origin_q <= '0;
			u_step_q   <= STEP_RST;
			v_step_q   <= STEP_RST;
			u_cells_q  <= CELLS_RST;
			v_cells_q  <= CELLS_RST;
		end else if (cmd.cfg_we) begin
			case (cfg_index)
				REG_U_ORIGIN: u_origin_q <= cfg_data;
				REG_V_ORIGIN: v_origin_q <= cfg_data;
				REG_U_STEP:   u_step_q   <= cfg_data[STEP_W-1:0];
				REG_V_STEP:   v_step_q   <= cfg_data[STEP_W-1:0];
				REG_U_CELLS:  u_cells_q  <= cfg_data[CELLS_W-1:0];
				REG_V_CELLS:  v_cells_q  <= cfg_data[CELLS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		nc = u_cells_q;
		if (u_cells_q == '0) begin
			nc = CELLS_W'(1);
		end else if (32'(u_cells_q) > MAX_COLS) begin
			nc = CELLS_W'(MAX_COLS);
		end
		nr = v_cells_q;
		if (v_cells_q == '0) begin
			nr = CELLS_W'(1);
		end else if (32'(v_cells_q) > MAX_ROWS) begin
			nr = CELLS_W'(MAX_ROWS);
		end
		area = EW'((2*CELLS_W)'(nc) * (2*CELLS_W)'(nr));
	end

	gph_div u_div_u (
		.clk     (clk),
		.load    (cmd.in_load),
		.advance (cmd.div_step),
		.coord   (in_data.u_coord),
		.origin  (u_origin_q),
		.pitch   (u_step_q),
		.quo     (q_u)
	);

	gph_div u_div_v (
		.clk     (clk),
		.load    (cmd.in_load),
		.advance (cmd.div_step),
		.coord   (in_data.v_coord),
		.origin  (v_origin_q),
		.pitch   (v_step_q),
		.quo     (q_r)
	);

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			req_q  <= in_data.req_type;
			rcol_q <= in_data.read_col;
			rrow_q <= in_data.read_row;
		end
	end

	assign pt_hit = !q_u[QUO_W-1] && (q_u[QUO_W-2:0] < nc) &&
		!q_r[QUO_W-1] && (q_r[QUO_W-2:0] < nr);
	assign rd_hit = ({1'b0, rcol_q} < nc) && ({1'b0, rrow_q} < nr);
	assign pt_addr = AW'(RW'(q_r[QUO_W-2:0])) * COLS_A + AW'(CW'(q_u[QUO_W-2:0]));
	assign rd_addr_pt = AW'(RW'(rrow_q)) * COLS_A + AW'(CW'(rcol_q));
	assign look_hit  = (req_q == REQ_ADD) ? pt_hit : rd_hit;
	assign look_addr = (req_q == REQ_ADD) ? pt_addr : rd_addr_pt;

	assign lim_c = cmd.swp_full ? COL_LAST : CW'(nc - CELLS_W'(1));
	assign lim_r = cmd.swp_full ? ROW_LAST : RW'(nr - CELLS_W'(1));
	assign sts.swp_last = (swp_col_q == lim_c) && (swp_row_q == lim_r);
	assign sts.req      = in_data.req_type;
	assign swp_addr     = AW'(swp_row_q) * COLS_A + AW'(swp_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swp_col_q <= '0;
			swp_row_q <= '0;
		end else if (cmd.swp_init) begin
			swp_col_q <= '0;
			swp_row_q <= '0;
		end else if (cmd.swp_adv) begin
			if (swp_col_q == lim_c) begin
				swp_col_q <= '0;
				swp_row_q <= swp_row_q + RW'(1);
			end else begin
				swp_col_q <= swp_col_q + CW'(1);
			end
		end
	end

	assign cnt_new = (&rd_q) ? rd_q : rd_q + COUNT_BITS'(1);
	assign mem_we  = cmd.clr_wr || (cmd.fin && (req_q == REQ_ADD) && pt_hit);
	assign mem_wa  = cmd.clr_wr ? swp_addr : pt_addr;
	assign mem_wd  = cmd.clr_wr ? '0 : cnt_new;
	assign rd_en   = cmd.rc_rd || (cmd.look && look_hit);
	assign mem_ra  = cmd.rc_rd ? swp_addr : look_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_q <= mem[mem_ra];
		end
	end

	assign acc_nxt = acc_q + EW'(rc_v_s1 && (rd_q == '0));

	always_comb begin
		empty_nxt = empty_q;
		if (cmd.empty_fill) begin
			empty_nxt = area;
		end else if (cmd.rc_commit) begin
			empty_nxt = acc_nxt;
		end else if (cmd.fin) begin
			case (req_q)
				REQ_ADD: begin
					if (pt_hit && (rd_q == '0) && (empty_q != '0)) begin
						empty_nxt = empty_q - EW'(1);
					end
				end
				REQ_CLEAR: empty_nxt = area;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= EW'(EMPTY_RST);
			acc_q   <= '0;
			rc_v_s1 <= 1'b0;
		end else begin
			empty_q <= empty_nxt;
			acc_q   <= cmd.swp_init ? '0 : acc_nxt;
			rc_v_s1 <= cmd.rc_rd;
		end
	end

	always_comb begin
		res = '0;
		res.empty_cells = OUT_EMPTY_W'(empty_nxt);
		case (req_q)
			REQ_ADD: begin
				res.cell_col = (pt_hit || !(|q_u[QUO_W-1:QUO_W-2])) ? q_u[5:0] : 6'd63;
				res.cell_row = (pt_hit || !(|q_r[QUO_W-1:QUO_W-2])) ? q_r[5:0] : 6'd63;
				res.in_grid    = pt_hit;
				res.cell_count = pt_hit ? sat_count(32'(cnt_new)) : '0;
			end
			REQ_READ: begin
				res.cell_col   = rcol_q;
				res.cell_row   = rrow_q;
				res.in_grid    = rd_hit;
				res.cell_count = rd_hit ? sat_count(32'(rd_q)) : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q <= res;
		end
	end

	assign out_data = out_q;

`ifndef ASSERT_OFF
	a_idle_rsp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && (req_q != REQ_ADD) && (req_q != REQ_READ)
		|=> !out_q.in_grid && (out_q.cell_count == '0) && (out_q.cell_col == '0))
		else $error("clear or unused request gave a nonzero result");
	a_add_counted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && (req_q == REQ_ADD) && pt_hit
		|=> out_q.in_grid && (out_q.cell_count != '0))
		else $error("counted point reports zero count");
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && (req_q == REQ_CLEAR) |=> (empty_q == area))
		else $error("empty count wrong after clear");
	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("store read and write in the same cycle");
`endif

endmodule

>>> design/gph_ctrl.sv
// Controller state machine: handshakes, divide sequencing, clear and recount sweeps.
module gph_ctrl import gph_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  gph_sts_t             sts,
	output gph_cmd_t             cmd
);

	localparam int SW = $clog2(DIV_STEPS);

	gph_state_t    state_q, state_d;
	logic [SW-1:0] cnt_q;
	logic          out_valid_q;
	logic          out_free, cells_wr;

	assign out_free  = !out_valid_q || out_ready;
	assign cells_wr  = (cfg_index == REG_U_CELLS) || (cfg_index == REG_V_CELLS);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.clr_wr   = 1'b1;
				cmd.swp_adv  = 1'b1;
				cmd.swp_full = 1'b1;
				if (sts.swp_last) begin
					cmd.empty_fill = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.swp_init = 1'b1;
				cfg_ready    = 1'b1;
				in_ready     = !cfg_valid;
				if (cfg_valid && cells_wr) begin
					state_d = ST_RCNT;
				end else if (in_valid && !cfg_valid) begin
					cmd.in_load = 1'b1;
					case (sts.req)
						REQ_ADD:   state_d = ST_DIV;
						REQ_READ:  state_d = ST_LOOK;
						REQ_CLEAR: state_d = ST_CLR;
						default:   state_d = ST_FIN;
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == SW'(DIV_STEPS - 1)) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CLR: begin
				cmd.clr_wr   = 1'b1;
				cmd.swp_adv  = 1'b1;
				cmd.swp_full = 1'b1;
				if (sts.swp_last) begin
					state_d = ST_FIN;
				end
			end
			ST_RCNT: begin
				cmd.rc_rd   = 1'b1;
				cmd.swp_adv = 1'b1;
				if (sts.swp_last) begin
					state_d = ST_RCEND;
				end
			end
			ST_RCEND: begin
				cmd.rc_commit = 1'b1;
				state_d       = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.cfg_we = cfg_valid && cfg_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == ST_DIV) ? cnt_q + SW'(1) : '0;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transfer taken while an item is in flight");
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finish step");
	a_look_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> ($past(state_q == ST_DIV) || $past(in_valid && in_ready)))
		else $error("lookup entered without a divide or read request");
`endif

endmodule

>>> design/grid_point_histogram_core.sv
// Top level of the grid point histogram: controller plus datapath.
//
//  channel | signals                          | role
//  --------+----------------------------------+------------------------------------
//  in      | in_valid in_ready in_data        | request: add point, read, clear
//  out     | out_valid out_ready out_data     | one result per request
//  cfg     | cfg_valid cfg_ready cfg_index    | register write, index 0..5
//          | cfg_data                         |
//
// An add occupies the transfer, 8 divider steps, one store read and one update;
// a read the transfer, one store read and the finish; the unused code the
// transfer and the finish. out_valid rises the cycle after. Clear sweeps the
// whole store, then gives its result. After reset a clearing pass over the whole
// store holds in_ready low. cfg_ready is high only while no item is in flight.
// A u_cells or v_cells write recounts empty cells over the active columns and rows
// with cfg_ready, in_ready low. A full result register stalls only the finish step.
module grid_point_histogram_core import gph_pkg::*; #(
	parameter int MAX_COLS   = 64,
	parameter int MAX_ROWS   = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  gph_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output gph_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	gph_cmd_t cmd;
	gph_sts_t sts;

	gph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.sts       (sts),
		.cmd       (cmd)
	);

	gph_datapath #(
		.MAX_COLS   (MAX_COLS),
		.MAX_ROWS   (MAX_ROWS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
